FILE: sv/chs_pkg.sv
// chs_pkg: shared widths, status codes, register indexes and reset values
// for the cubic hermite curve sampler. no dependencies.

package chs_pkg;

   localparam int FRAC_BITS = 16;
   localparam int T_LIMIT   = 4;

   localparam int WORD_W   = 32;
   localparam int MAG_W    = 32;
   localparam int STATUS_W = 2;
   localparam int CSR_INDEX_W = 3;

   // time limit in fixed point and quotient width (2**QW exceeds the limit)
   localparam int LIMIT = T_LIMIT << FRAC_BITS;
   localparam int QW    = $clog2(LIMIT) + 1;
   localparam int PRE_W = QW - FRAC_BITS;
   localparam int TOP_W = MAG_W - PRE_W;

   // time, time squared, time cubed, basis, scaled product and sum widths
   localparam int TW  = QW + 1;
   localparam int T2W = 2 * QW - FRAC_BITS + 1;
   localparam int T3W = 3 * QW - 2 * FRAC_BITS + 1;
   localparam int HW  = T3W + 3;
   localparam int PW  = HW + WORD_W - FRAC_BITS;
   localparam int SW  = PW + 2;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic [STATUS_W-1:0]      status_type;
   typedef logic [CSR_INDEX_W-1:0]   csr_index_type;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_ZERO_SPAN = 2'd1;
   localparam status_type STATUS_OUTSIDE   = 2'd2;
   localparam status_type STATUS_SATURATED = 2'd3;

   localparam csr_index_type CSR_START_X     = 3'd0;
   localparam csr_index_type CSR_END_X       = 3'd1;
   localparam csr_index_type CSR_START_Y     = 3'd2;
   localparam csr_index_type CSR_END_Y       = 3'd3;
   localparam csr_index_type CSR_START_SLOPE = 3'd4;
   localparam csr_index_type CSR_END_SLOPE   = 3'd5;

   localparam word_type END_X_RESET = 32'sd65536;
   localparam word_type WORD_MAX    = 32'sh7fffffff;
   localparam word_type WORD_MIN    = 32'sh80000000;

   localparam logic signed [HW-1:0] ONE_H = HW'(longint'(1) << FRAC_BITS);

   typedef struct packed {
      logic valid;
      logic zero;
      logic neg;
      logic outside;
   } flag_type;

endpackage

FILE: sv/chs_channel_if.sv
// chs channel interfaces: request word, response word and register write.
// depends on chs_pkg.

interface chs_req_if;
   logic               valid;
   logic               ready;
   chs_pkg::word_type  sample_x;
   modport source (output valid, output sample_x, input ready);
   modport sink   (input valid, input sample_x, output ready);
endinterface

interface chs_rsp_if;
   logic                valid;
   logic                ready;
   chs_pkg::word_type   sample_y;
   chs_pkg::status_type status;
   modport source (output valid, output sample_y, output status, input ready);
   modport sink   (input valid, input sample_y, input status, output ready);
endinterface

interface chs_csr_if;
   logic                   valid;
   logic                   ready;
   chs_pkg::csr_index_type index;
   chs_pkg::word_type      data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/cubic_hermite_curve_sampler.sv
// cubic_hermite_curve_sampler: pipelined cubic hermite curve evaluation.
// depends on chs_pkg and the chs channel interfaces.
//
//   channel   dir  payload                  handshake
//   req_bus   in   sample_x                 valid/ready
//   rsp_bus   out  sample_y, status         valid/ready
//   csr_bus   in   index, data              valid/ready (ready always high)
//
// one word per cycle while output words are taken; the restoring divider
// resolves one quotient bit per stage.
// reset clears the valid bits and the registers to their reset values.
// the whole pipeline holds while an output word waits; nothing is dropped.
// a write reaches the divider span through span_ff, then span_mag_ff.

module cubic_hermite_curve_sampler (
   input logic         clock,
   input logic         reset,
   chs_req_if.sink     req_bus,
   chs_rsp_if.source   rsp_bus,
   chs_csr_if.sink     csr_bus
);

   localparam int QW    = chs_pkg::QW;
   localparam int MAG_W = chs_pkg::MAG_W;
   localparam int W     = chs_pkg::WORD_W;
   localparam int F     = chs_pkg::FRAC_BITS;
   localparam int TW    = chs_pkg::TW;
   localparam int T2W   = chs_pkg::T2W;
   localparam int T3W   = chs_pkg::T3W;
   localparam int HW    = chs_pkg::HW;
   localparam int PW    = chs_pkg::PW;
   localparam int SW    = chs_pkg::SW;
   localparam int PRE_W = chs_pkg::PRE_W;

   // register file
   chs_pkg::word_type start_x_ff, end_x_ff, start_y_ff, end_y_ff;
   chs_pkg::word_type start_slope_ff, end_slope_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff     <= '0;
         end_x_ff       <= chs_pkg::END_X_RESET;
         start_y_ff     <= '0;
         end_y_ff       <= '0;
         start_slope_ff <= '0;
         end_slope_ff   <= '0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            chs_pkg::CSR_START_X:     start_x_ff     <= csr_bus.data;
            chs_pkg::CSR_END_X:       end_x_ff       <= csr_bus.data;
            chs_pkg::CSR_START_Y:     start_y_ff     <= csr_bus.data;
            chs_pkg::CSR_END_Y:       end_y_ff       <= csr_bus.data;
            chs_pkg::CSR_START_SLOPE: start_slope_ff <= csr_bus.data;
            chs_pkg::CSR_END_SLOPE:   end_slope_ff   <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // span, derived from the register file
   logic [W:0]       span_in, span_ff;
   logic [MAG_W-1:0] span_mag_in, span_mag_ff;
   logic             span_zero_in, span_zero_ff;

   assign span_in      = {end_x_ff[W-1], end_x_ff} - {start_x_ff[W-1], start_x_ff};
   assign span_mag_in  = span_ff[W] ? MAG_W'(-span_ff) : MAG_W'(span_ff);
   assign span_zero_in = (span_ff == '0);

   always_ff @(posedge clock) begin
      span_ff      <= span_in;
      span_mag_ff  <= span_mag_in;
      span_zero_ff <= span_zero_in;
   end

   // pipeline advance
   logic out_valid_ff;
   logic en;

   assign en            = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = en;

   // stage 1: offset
   logic             s1_valid_ff;
   logic [W:0]       s1_offs_in, s1_offs_ff;

   assign s1_offs_in = {req_bus.sample_x[W-1], req_bus.sample_x}
                     - {start_x_ff[W-1], start_x_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_offs_ff <= s1_offs_in;
      end
   end

   // stage 2: magnitude and quotient sign
   chs_pkg::flag_type s2_flag_in, s2_flag_ff;
   logic [MAG_W-1:0]  s2_mag_in, s2_mag_ff;

   always_comb begin
      s2_flag_in         = '0;
      s2_flag_in.valid   = s1_valid_ff;
      s2_flag_in.neg     = s1_offs_ff[W] ^ span_ff[W];
      s2_mag_in          = s1_offs_ff[W] ? MAG_W'(-s1_offs_ff) : MAG_W'(s1_offs_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_flag_ff <= '0;
      end else if (en) begin
         s2_flag_ff <= s2_flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_mag_ff <= s2_mag_in;
      end
   end

   // divider: entry stage checks quotient overflow, then one bit per stage
   chs_pkg::flag_type dv_flag_in [QW+1];
   chs_pkg::flag_type dv_flag_ff [QW+1];
   logic [MAG_W-1:0]  dv_r_in    [QW+1];
   logic [MAG_W-1:0]  dv_r_ff    [QW+1];
   logic [QW-1:0]     dv_lo_in   [QW+1];
   logic [QW-1:0]     dv_lo_ff   [QW+1];
   logic [QW-1:0]     dv_q_in    [QW+1];
   logic [QW-1:0]     dv_q_ff    [QW+1];

   always_comb begin
      dv_flag_in[0]         = s2_flag_ff;
      dv_flag_in[0].zero    = span_zero_ff;
      dv_flag_in[0].outside = MAG_W'(s2_mag_ff[MAG_W-1:PRE_W]) >= span_mag_ff;
      dv_r_in[0]            = MAG_W'(s2_mag_ff[MAG_W-1:PRE_W]);
      dv_lo_in[0]           = {s2_mag_ff[PRE_W-1:0], F'(0)};
      dv_q_in[0]            = '0;
   end

   for (genvar k = 1; k <= QW; k++) begin : g_div
      logic [MAG_W:0] rem2;
      logic [MAG_W:0] diff;
      logic           ge;

      assign rem2 = {dv_r_ff[k-1], dv_lo_ff[k-1][QW-1]};
      assign diff = rem2 - {1'b0, span_mag_ff};
      assign ge   = (rem2 >= {1'b0, span_mag_ff});

      assign dv_flag_in[k] = dv_flag_ff[k-1];
      assign dv_r_in[k]    = ge ? diff[MAG_W-1:0] : rem2[MAG_W-1:0];
      assign dv_lo_in[k]   = {dv_lo_ff[k-1][QW-2:0], 1'b0};
      assign dv_q_in[k]    = {dv_q_ff[k-1][QW-2:0], ge};
   end

   for (genvar k = 0; k <= QW; k++) begin : g_div_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_flag_ff[k] <= '0;
         end else if (en) begin
            dv_flag_ff[k] <= dv_flag_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_r_ff[k]  <= dv_r_in[k];
            dv_lo_ff[k] <= dv_lo_in[k];
            dv_q_ff[k]  <= dv_q_in[k];
         end
      end
   end

   // signed time and band check
   chs_pkg::flag_type     tq_flag_in, tq_flag_ff;
   logic signed [TW-1:0]  tq_t_in, tq_t_ff;
   logic signed [TW-1:0]  q_ext;

   assign q_ext = $signed({1'b0, dv_q_ff[QW]});

   always_comb begin
      tq_flag_in         = dv_flag_ff[QW];
      tq_flag_in.outside = dv_flag_ff[QW].outside || (dv_q_ff[QW] > QW'(chs_pkg::LIMIT));
      tq_t_in            = dv_flag_ff[QW].neg ? -q_ext : q_ext;
   end

   // square, cube
   chs_pkg::flag_type          m1_flag_ff, m2_flag_ff;
   logic signed [TW-1:0]       m1_t_ff, m2_t_ff;
   logic signed [2*TW-1:0]     m1_tt_in, m1_tt_ff;
   logic signed [T2W-1:0]      t2_w, m2_t2_ff;
   logic signed [T2W+TW-1:0]   m2_t2t_in, m2_t2t_ff;

   assign m1_tt_in  = tq_t_ff * tq_t_ff;
   assign t2_w      = T2W'(m1_tt_ff >>> F);
   assign m2_t2t_in = t2_w * m1_t_ff;

   // hermite basis
   chs_pkg::flag_type     hb_flag_ff;
   logic signed [T3W-1:0] t3_w;
   logic signed [HW-1:0]  t_x, t2_x, t3_x;
   logic signed [HW-1:0]  h1_in, h2_in, h3_in, h4_in;
   logic signed [HW-1:0]  h1_ff, h2_ff, h3_ff, h4_ff;

   assign t3_w  = T3W'(m2_t2t_ff >>> F);
   assign t_x   = HW'(m2_t_ff);
   assign t2_x  = HW'(m2_t2_ff);
   assign t3_x  = HW'(t3_w);
   assign h1_in = (t3_x <<< 1) - (t2_x <<< 1) - t2_x + chs_pkg::ONE_H;
   assign h2_in = t3_x - (t2_x <<< 1) + t_x;
   assign h3_in = (t2_x <<< 1) + t2_x - (t3_x <<< 1);
   assign h4_in = t3_x - t2_x;

   // scaled products
   chs_pkg::flag_type      pr_flag_ff;
   logic signed [HW+W-1:0] full_a, full_b, full_c, full_d;
   logic signed [PW-1:0]   pa_ff, pb_ff, pc_ff, pd_ff;

   assign full_a = h1_ff * start_y_ff;
   assign full_b = h2_ff * start_slope_ff;
   assign full_c = h3_ff * end_y_ff;
   assign full_d = h4_ff * end_slope_ff;

   // sum tree
   chs_pkg::flag_type    sa_flag_ff, sb_flag_ff;
   logic signed [SW-1:0] sa_lo_in, sa_hi_in, sa_lo_ff, sa_hi_ff;
   logic signed [SW-1:0] sum_in, sum_ff;

   assign sa_lo_in = SW'(pa_ff) + SW'(pb_ff);
   assign sa_hi_in = SW'(pc_ff) + SW'(pd_ff);
   assign sum_in   = sa_lo_ff + sa_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tq_flag_ff <= '0;
         m1_flag_ff <= '0;
         m2_flag_ff <= '0;
         hb_flag_ff <= '0;
         pr_flag_ff <= '0;
         sa_flag_ff <= '0;
         sb_flag_ff <= '0;
      end else if (en) begin
         tq_flag_ff <= tq_flag_in;
         m1_flag_ff <= tq_flag_ff;
         m2_flag_ff <= m1_flag_ff;
         hb_flag_ff <= m2_flag_ff;
         pr_flag_ff <= hb_flag_ff;
         sa_flag_ff <= pr_flag_ff;
         sb_flag_ff <= sa_flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tq_t_ff   <= tq_t_in;
         m1_t_ff   <= tq_t_ff;
         m1_tt_ff  <= m1_tt_in;
         m2_t_ff   <= m1_t_ff;
         m2_t2_ff  <= t2_w;
         m2_t2t_ff <= m2_t2t_in;
         h1_ff     <= h1_in;
         h2_ff     <= h2_in;
         h3_ff     <= h3_in;
         h4_ff     <= h4_in;
         pa_ff     <= PW'(full_a >>> F);
         pb_ff     <= PW'(full_b >>> F);
         pc_ff     <= PW'(full_c >>> F);
         pd_ff     <= PW'(full_d >>> F);
         sa_lo_ff  <= sa_lo_in;
         sa_hi_ff  <= sa_hi_in;
         sum_ff    <= sum_in;
      end
   end

   // saturation and status, output register
   logic                 sat;
   chs_pkg::word_type    out_y_in, out_y_ff;
   chs_pkg::status_type  out_status_in, out_status_ff;

   assign sat = !((&sum_ff[SW-1:W-1]) || !(|sum_ff[SW-1:W-1]));

   always_comb begin
      if (sb_flag_ff.zero) begin
         out_y_in      = '0;
         out_status_in = chs_pkg::STATUS_ZERO_SPAN;
      end else if (sb_flag_ff.outside) begin
         out_y_in      = '0;
         out_status_in = chs_pkg::STATUS_OUTSIDE;
      end else if (sat) begin
         out_y_in      = sum_ff[SW-1] ? chs_pkg::WORD_MIN : chs_pkg::WORD_MAX;
         out_status_in = chs_pkg::STATUS_SATURATED;
      end else begin
         out_y_in      = sum_ff[W-1:0];
         out_status_in = chs_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= sb_flag_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_y_ff      <= out_y_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.sample_y = out_y_ff;
   assign rsp_bus.status   = out_status_ff;

endmodule

FILE: sv/chs_checker.sv
// chs_checker: port-level assertions for the curve sampler, bound to the
// top level. depends on chs_pkg and cubic_hermite_curve_sampler.

module chs_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input chs_pkg::word_type   sample_y,
   input chs_pkg::status_type status
);

   // a waiting word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(sample_y) && $stable(status))
      else $error("response word changed while stalled");

   // zero span and out of band give zero
   a_zero_y: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == chs_pkg::STATUS_ZERO_SPAN ||
                    status == chs_pkg::STATUS_OUTSIDE) |-> sample_y == '0)
      else $error("nonzero value with zero span or out of band status");

   // saturated word sits on a bound
   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == chs_pkg::STATUS_SATURATED |->
         sample_y == chs_pkg::WORD_MAX || sample_y == chs_pkg::WORD_MIN)
      else $error("saturated status without a bound value");

   // empty output never blocks the input
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   // no word right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind cubic_hermite_curve_sampler chs_checker u_chs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .sample_y  (rsp_bus.sample_y),
   .status    (rsp_bus.status)
);

FILE: verif/cubic_hermite_curve_sampler_checker.sv
// cubic_hermite_curve_sampler_checker: watches the request, response and register
// channels, predicts each curve sample and compares the response words in order.
// depends on chs_pkg and the chs channel interfaces.

module cubic_hermite_curve_sampler_checker (
   input  logic clock,
   input  logic reset,
   chs_req_if   req_bus,
   chs_rsp_if   rsp_bus,
   chs_csr_if   csr_bus,
   output int   mismatches,
   output int   pending
);
   import chs_pkg::*;

   typedef struct packed {
      word_type   y;
      status_type status;
   } curve_point_type;

   curve_point_type expected_points[$];

   word_type start_x, end_x, start_y, end_y, start_slope, end_slope;

   function automatic curve_point_type evaluate_curve(input word_type x);
      longint one, span, offs, t, t2, t3, limit, total;
      longint h00, h10, h01, h11;
      curve_point_type p;
      one = longint'(1) << FRAC_BITS;
      span = longint'(end_x) - longint'(start_x);
      offs = longint'(x) - longint'(start_x);
      p.y = '0;
      p.status = STATUS_OK;
      if (span == 0) begin
         p.status = STATUS_ZERO_SPAN;
      end else begin
         // integer division truncates toward zero
         t = (offs * one) / span;
         limit = longint'(T_LIMIT) * one;
         if (t > limit || t < -limit) begin
            p.status = STATUS_OUTSIDE;
         end else begin
            t2 = (t * t) >>> FRAC_BITS;
            t3 = (t2 * t) >>> FRAC_BITS;
            h00 = 2 * t3 - 3 * t2 + one;
            h10 = t3 - 2 * t2 + t;
            h01 = -2 * t3 + 3 * t2;
            h11 = t3 - t2;
            total = ((h00 * longint'(start_y)) >>> FRAC_BITS)
                  + ((h10 * longint'(start_slope)) >>> FRAC_BITS)
                  + ((h01 * longint'(end_y)) >>> FRAC_BITS)
                  + ((h11 * longint'(end_slope)) >>> FRAC_BITS);
            if (total > longint'(WORD_MAX)) begin
               p.y = WORD_MAX;
               p.status = STATUS_SATURATED;
            end else if (total < longint'(WORD_MIN)) begin
               p.y = WORD_MIN;
               p.status = STATUS_SATURATED;
            end else begin
               p.y = word_type'(total);
            end
         end
      end
      return p;
   endfunction

   always @(posedge clock) begin
      curve_point_type want;
      if (reset) begin
         start_x = '0;
         end_x = END_X_RESET;
         start_y = '0;
         end_y = '0;
         start_slope = '0;
         end_slope = '0;
         mismatches = 0;
         expected_points.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_START_X:     start_x = csr_bus.data;
               CSR_END_X:       end_x = csr_bus.data;
               CSR_START_Y:     start_y = csr_bus.data;
               CSR_END_Y:       end_y = csr_bus.data;
               CSR_START_SLOPE: start_slope = csr_bus.data;
               CSR_END_SLOPE:   end_slope = csr_bus.data;
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready)
            expected_points.push_back(evaluate_curve(req_bus.sample_x));
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_points.size() == 0) begin
               mismatches++;
               $display("%0t: expected no word, got sample_y %h status %0d",
                        $time, rsp_bus.sample_y, rsp_bus.status);
            end else begin
               want = expected_points.pop_front();
               if (rsp_bus.sample_y !== want.y) begin
                  mismatches++;
                  $display("%0t: sample_y expected %h got %h",
                           $time, want.y, rsp_bus.sample_y);
               end
               if (rsp_bus.status !== want.status) begin
                  mismatches++;
                  $display("%0t: status expected %0d got %0d",
                           $time, want.status, rsp_bus.status);
               end
            end
         end
      end
      pending = expected_points.size();
   end

endmodule

FILE: verif/cubic_hermite_curve_sampler_tb.sv
// cubic_hermite_curve_sampler_tb: drives directed and random curve settings and
// abscissas with random idling on both sides; the checker module does the compare.
// depends on chs_pkg, the chs channel interfaces, the block and its checker.

module cubic_hermite_curve_sampler_tb;
   import chs_pkg::*;

   localparam int LATENCY = QW + 11;
   localparam int HOLD_CYCLES = 160;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_ITEMS = 1100;
   localparam csr_index_type CSR_UNMAPPED_LO = 3'd6;
   localparam csr_index_type CSR_UNMAPPED_HI = 3'd7;
   localparam longint ONE = longint'(1) << FRAC_BITS;

   logic     clock;
   logic     reset;
   int       failures;
   int       pending;
   int       cycles;
   bit       send_gaps;
   bit       hold_rsp;
   bit       rsp_quiet;
   word_type cur_start_x;
   word_type cur_end_x;

   chs_req_if req_bus();
   chs_rsp_if rsp_bus();
   chs_csr_if csr_bus();

   cubic_hermite_curve_sampler dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   cubic_hermite_curve_sampler_checker curve_check (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_bus    (csr_bus),
      .mismatches (failures),
      .pending    (pending)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_reg(input csr_index_type index, input word_type data);
      csr_bus.valid = 1;
      csr_bus.index = index;
      csr_bus.data = data;
      @(posedge clock);
      while (!(csr_bus.valid && csr_bus.ready)) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic load_curve(input word_type sx, ex, sy, ey, ss, es);
      req_bus.valid = 0;
      while (pending != 0) @(negedge clock);
      write_reg($urandom_range(0, 1) ? CSR_UNMAPPED_LO : CSR_UNMAPPED_HI, word_type'($urandom));
      write_reg(CSR_START_X, sx);
      write_reg(CSR_END_X, ex);
      write_reg(CSR_START_Y, sy);
      write_reg(CSR_END_Y, ey);
      write_reg(CSR_START_SLOPE, ss);
      write_reg(CSR_END_SLOPE, es);
      csr_bus.valid = 0;
      cur_start_x = sx;
      cur_end_x = ex;
      // let the written registers reach the datapath before sending
      repeat (4) @(negedge clock);
   endtask

   task automatic send_sample(input word_type x);
      int gap;
      gap = send_gaps ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
         req_bus.valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid = 1;
      req_bus.sample_x = x;
      @(posedge clock);
      while (!(req_bus.valid && req_bus.ready)) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic word_type random_level();
      return word_type'($signed($urandom) >>> $urandom_range(0, 24));
   endfunction

   // abscissa aimed at a curve time mostly inside the band
   function automatic word_type pick_sample();
      longint span;
      longint t_goal;
      int pick;
      span = longint'(cur_end_x) - longint'(cur_start_x);
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return word_type'($urandom);
      if (pick == 1)
         return word_type'(longint'(cur_start_x) + span * ($urandom_range(0, 1) ? 4 : -4)
                           + longint'($urandom_range(0, 6)) - 3);
      t_goal = longint'($urandom_range(0, 10 * 65536)) - 5 * ONE;
      return word_type'(longint'(cur_start_x) + ((span * t_goal) >>> FRAC_BITS));
   endfunction

   task automatic random_curve();
      word_type sx;
      longint span;
      int kind;
      kind = $urandom_range(0, 9);
      sx = word_type'($urandom_range(0, 32'h1f_ffff)) - 32'sh10_0000;
      span = longint'($urandom_range(1, 1 << $urandom_range(1, 24)));
      if ($urandom_range(0, 1))
         span = -span;
      case (kind)
         0: load_curve(word_type'($urandom), word_type'($urandom), word_type'($urandom),
                       word_type'($urandom), word_type'($urandom), word_type'($urandom));
         1: load_curve(sx, sx, random_level(), random_level(), random_level(),
                       random_level());
         default: load_curve(sx, word_type'(longint'(sx) + span), random_level(),
                             random_level(), random_level(), random_level());
      endcase
   endtask

   // response side
   initial begin
      int n;
      int taken;
      rsp_bus.ready = 0;
      taken = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_bus.ready = 0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 0;
         end
         n = rsp_quiet ? 0 : $urandom_range(0, 12);
         if (n > 0) begin
            rsp_bus.ready = 0;
            repeat (n) @(negedge clock);
         end
         rsp_bus.ready = 1;
         @(posedge clock);
         while (!(rsp_bus.valid && rsp_bus.ready)) @(posedge clock);
         @(negedge clock);
         taken++;
         if (taken % 64 == 0)
            rsp_quiet = ($urandom_range(0, 2) == 0);
      end
   end

   // request side
   initial begin
      word_type reset_probe[8];
      int random_sent;
      int phase;
      int n;
      req_bus.valid = 0;
      req_bus.sample_x = '0;
      csr_bus.valid = 0;
      csr_bus.index = CSR_START_X;
      csr_bus.data = '0;
      reset = 1;
      send_gaps = 0;
      hold_rsp = 0;
      rsp_quiet = 0;
      cur_start_x = '0;
      cur_end_x = END_X_RESET;
      random_sent = 0;
      phase = 0;
      reset_probe = '{word_type'(0), word_type'(ONE), word_type'(4 * ONE),
                      word_type'(4 * ONE + 1), word_type'(-4 * ONE),
                      word_type'(-4 * ONE - 1), WORD_MAX, WORD_MIN};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // curve after reset, band edges and word extremes
      foreach (reset_probe[i])
         send_sample(reset_probe[i]);

      // zero span
      load_curve(word_type'(12345), word_type'(12345), WORD_MAX, WORD_MIN,
                 word_type'(1), word_type'(-1));
      send_sample(word_type'(12345));
      send_sample(WORD_MIN);

      // saturation high and low
      load_curve(word_type'(0), word_type'(ONE), WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      send_sample(word_type'(0));
      send_sample(word_type'(ONE / 2));
      send_sample(word_type'(4 * ONE));
      send_sample(word_type'(-4 * ONE));
      load_curve(word_type'(0), word_type'(ONE), WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
      send_sample(word_type'(3 * ONE));
      send_sample(word_type'(-3 * ONE));

      // widest span, both directions
      load_curve(WORD_MIN, WORD_MAX, word_type'(ONE), word_type'(-ONE),
                 word_type'(3 * ONE), word_type'(-2 * ONE));
      send_sample(WORD_MIN);
      send_sample(WORD_MAX);
      send_sample(word_type'(0));
      load_curve(WORD_MAX, WORD_MIN, word_type'(-ONE), word_type'(ONE),
                 word_type'(0), WORD_MAX);
      send_sample(WORD_MAX);
      send_sample(word_type'(0));

      while (random_sent < RANDOM_ITEMS) begin
         random_curve();
         send_gaps = ($urandom_range(0, 3) != 0);
         if (phase == 2) begin
            // back-to-back words against a stalled response side
            send_gaps = 0;
            hold_rsp = 1;
         end
         n = $urandom_range(60, 140);
         repeat (n) begin
            send_sample(pick_sample());
            random_sent++;
         end
         phase++;
      end

      req_bus.valid = 0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      if (failures == 0 && pending == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
